>>> sv/hpq_pkg.sv
// Types, constants and the key compare shared by the binary heap priority queue.
`timescale 1ns / 1ps
package hpq_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam logic [2:0] ActInsert  = 3'd0;
  localparam logic [2:0] ActExtract = 3'd1;
  localparam logic [2:0] ActPeek    = 3'd2;
  localparam logic [2:0] ActRaise   = 3'd3;
  localparam logic [2:0] ActRemove  = 3'd4;
  localparam logic [2:0] ActDrain   = 3'd5;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEmpty   = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StBadIdx  = 3'd3;
  localparam logic [2:0] StNotImpr = 3'd4;

  typedef struct packed {
    logic [2:0]        action;
    logic signed [31:0] key_value;
    logic [4:0]        slot_index;
  } hpq_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]        status;
    logic [5:0]        entry_count;
    logic              last;
  } hpq_out_t;

  // True when key a belongs strictly nearer the root than key b.
  function automatic logic better(input logic max_mode, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
    better = max_mode ? (a > b) : (a < b);
  endfunction

endpackage

>>> sv/binary_heap_priority_queue_unit.sv
// Binary heap priority queue held in one synchronous memory with a sequencer.
// Insert, raise, extract and remove walk the heap one level at a time, so they take longer
// on a deeper heap; peek only reads the root.
// Sort drain runs one extract per key, then emits the keys one at a time, each read from memory first.
// Throughput is one command at a time; the single memory read port sets the pace.
// Reset empties the heap and selects max mode; the receiver cannot stall results.
`timescale 1ns / 1ps
module binary_heap_priority_queue_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  hpq_pkg::hpq_in_t cmd_i,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  output logic            result_valid_o,
  output hpq_pkg::hpq_out_t result_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_TR_A   = 15'b000000000000010,
    S_TR_B   = 15'b000000000000100,
    S_PK     = 15'b000000000001000,
    S_RK     = 15'b000000000010000,
    S_RM_A   = 15'b000000000100000,
    S_RM_B   = 15'b000000001000000,
    S_SU_CHK = 15'b000000010000000,
    S_SU_CMP = 15'b000000100000000,
    S_SD_L   = 15'b000001000000000,
    S_SD_R   = 15'b000010000000000,
    S_SD_CMP = 15'b000100000000000,
    S_DR_NXT = 15'b001000000000000,
    S_EM_RD  = 15'b010000000000000,
    S_EM_OUT = 15'b100000000000000
  } state_e;

  localparam int unsigned IdxW = hpq_pkg::IdxW;
  localparam int unsigned CntW = hpq_pkg::CntW;

  logic signed [31:0] mem [hpq_pkg::Depth];

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d, n_q, n_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic signed [31:0]    key_q, key_d, val_q, val_d, lv_q, lv_d, rd_q;
  logic                  rvalid_q, rvalid_d, down_q, down_d, drain_q, drain_d;
  logic                  mode_q;
  hpq_pkg::hpq_out_t     res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic                  we;
  logic [IdxW-1:0]       wa, ra;
  logic signed [31:0]    wd;

  logic [CntW-1:0]       lch, rch;
  logic [IdxW-1:0]       par, top_idx;
  logic signed [31:0]    top_val;
  logic                  take;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign lch = {idx_q, 1'b1};
  assign rch = lch + CntW'(1);
  assign par = IdxW'((idx_q - IdxW'(1)) >> 1);

  always_comb begin
    top_val = key_q;
    top_idx = idx_q;
    take    = 1'b0;
    if (hpq_pkg::better(mode_q, lv_q, key_q)) begin
      top_val = lv_q;
      top_idx = lch[IdxW-1:0];
      take    = 1'b1;
    end
    if (rvalid_q && hpq_pkg::better(mode_q, rd_q, top_val)) begin
      top_val = rd_q;
      top_idx = rch[IdxW-1:0];
      take    = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    idx_d       = idx_q;
    key_d       = key_q;
    val_d       = val_q;
    lv_d        = lv_q;
    rvalid_d    = rvalid_q;
    down_d      = down_q;
    drain_d     = drain_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    we          = 1'b0;
    wa          = idx_q;
    wd          = key_q;
    ra          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d   = '0;
          key_d   = cmd_i.key_value;
          idx_d   = cmd_i.slot_index;
          drain_d = 1'b0;
          down_d  = 1'b0;
          res_d   = '{result_value: '0, status: hpq_pkg::StOk, entry_count: cnt_q, last: 1'b1};
          unique case (cmd_i.action) inside
            hpq_pkg::ActInsert: begin
              if (cnt_q == CntW'(hpq_pkg::Depth)) begin
                res_d.status = hpq_pkg::StFull;
                res_valid_d  = 1'b1;
              end else begin
                cnt_d   = cnt_q + CntW'(1);
                idx_d   = cnt_q[IdxW-1:0];
                state_d = S_SU_CHK;
              end
            end
            hpq_pkg::ActExtract, hpq_pkg::ActPeek, hpq_pkg::ActDrain: begin
              if (cnt_q == '0) begin
                res_d.status = hpq_pkg::StEmpty;
                res_valid_d  = 1'b1;
              end else begin
                ra      = '0;
                drain_d = (cmd_i.action == hpq_pkg::ActDrain);
                n_d     = cnt_q;
                state_d = (cmd_i.action == hpq_pkg::ActPeek) ? S_PK : S_TR_A;
              end
            end
            hpq_pkg::ActRaise: begin
              if ({1'b0, cmd_i.slot_index} >= cnt_q) begin
                res_d.status = hpq_pkg::StBadIdx;
                res_valid_d  = 1'b1;
              end else begin
                ra      = cmd_i.slot_index;
                state_d = S_RK;
              end
            end
            hpq_pkg::ActRemove: begin
              if (cnt_q == '0) begin
                res_d.status = hpq_pkg::StEmpty;
                res_valid_d  = 1'b1;
              end else if ({1'b0, cmd_i.slot_index} >= cnt_q) begin
                res_d.status = hpq_pkg::StBadIdx;
                res_valid_d  = 1'b1;
              end else begin
                ra      = cmd_i.slot_index;
                state_d = S_RM_A;
              end
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      S_TR_A: begin
        val_d   = rd_q;
        ra      = IdxW'(cnt_q - CntW'(1));
        cnt_d   = cnt_q - CntW'(1);
        state_d = S_TR_B;
      end
      S_TR_B: begin
        key_d = rd_q;
        idx_d = '0;
        if (drain_q) begin
          we = 1'b1;
          wa = cnt_q[IdxW-1:0];
          wd = val_q;
        end
        state_d = S_SD_L;
      end
      S_PK: begin
        res_d.result_value = rd_q;
        res_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end
      S_RK: begin
        if (hpq_pkg::better(mode_q, key_q, rd_q)) begin
          state_d = S_SU_CHK;
        end else begin
          res_d.status = hpq_pkg::StNotImpr;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RM_A: begin
        val_d   = rd_q;
        ra      = IdxW'(cnt_q - CntW'(1));
        cnt_d   = cnt_q - CntW'(1);
        state_d = S_RM_B;
      end
      S_RM_B: begin
        key_d = rd_q;
        if ({1'b0, idx_q} < cnt_q) begin
          down_d  = 1'b1;
          state_d = S_SU_CHK;
        end else begin
          res_d.result_value = val_q;
          res_d.entry_count  = cnt_q;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_SU_CHK: begin
        if (idx_q == '0) begin
          if (down_q) begin
            state_d = S_SD_L;
          end else begin
            we                 = 1'b1;
            res_d.result_value = val_q;
            res_d.entry_count  = cnt_q;
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end
        end else begin
          ra      = par;
          state_d = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (hpq_pkg::better(mode_q, key_q, rd_q)) begin
          we      = 1'b1;
          wd      = rd_q;
          idx_d   = par;
          down_d  = 1'b0;
          state_d = S_SU_CHK;
        end else if (down_q) begin
          state_d = S_SD_L;
        end else begin
          we                 = 1'b1;
          res_d.result_value = val_q;
          res_d.entry_count  = cnt_q;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_SD_L: begin
        if (lch >= cnt_q) begin
          we = 1'b1;
          if (drain_q) begin
            state_d = S_DR_NXT;
          end else begin
            res_d.result_value = val_q;
            res_d.entry_count  = cnt_q;
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end
        end else begin
          ra      = lch[IdxW-1:0];
          state_d = S_SD_R;
        end
      end
      S_SD_R: begin
        lv_d     = rd_q;
        rvalid_d = (rch < cnt_q);
        ra       = rch[IdxW-1:0];
        state_d  = S_SD_CMP;
      end
      S_SD_CMP: begin
        we = 1'b1;
        if (take) begin
          wd      = top_val;
          idx_d   = top_idx;
          state_d = S_SD_L;
        end else if (drain_q) begin
          state_d = S_DR_NXT;
        end else begin
          res_d.result_value = val_q;
          res_d.entry_count  = cnt_q;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_DR_NXT: begin
        if (cnt_q != '0) begin
          ra      = '0;
          state_d = S_TR_A;
        end else begin
          idx_d   = '0;
          state_d = S_EM_RD;
        end
      end
      S_EM_RD: begin
        ra      = idx_q;
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        res_d.result_value = rd_q;
        res_d.status       = hpq_pkg::StOk;
        res_d.entry_count  = '0;
        res_d.last         = ({1'b0, idx_q} + CntW'(1) == n_q);
        res_valid_d        = 1'b1;
        idx_d              = idx_q + IdxW'(1);
        state_d            = res_d.last ? S_IDLE : S_EM_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mode_q      <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    key_q    <= key_d;
    val_q    <= val_d;
    lv_q     <= lv_d;
    rvalid_q <= rvalid_d;
    down_q   <= down_d;
    drain_q  <= drain_d;
    res_q    <= res_d;
  end

endmodule

>>> tb/binary_heap_priority_queue_unit_tb.sv
// Randomized self-checking testbench for the binary heap priority queue unit.
`timescale 1ns / 1ps
module binary_heap_priority_queue_unit_tb;

  class heap_scoreboard;
    logic signed [31:0] keys[hpq_pkg::Depth];
    int unsigned held;
    bit max_first;
    hpq_pkg::hpq_out_t pending[$];
    int errors;

    function new();
      held = 0;
      max_first = 1'b1;
      errors = 0;
    endfunction

    function bit ranks_above(logic signed [31:0] a, logic signed [31:0] b);
      return max_first ? (a > b) : (a < b);
    endfunction

    function void bubble_up(int unsigned i, logic signed [31:0] k);
      while (i > 0 && ranks_above(k, keys[(i - 1) / 2])) begin
        keys[i] = keys[(i - 1) / 2];
        i = (i - 1) / 2;
      end
      keys[i] = k;
    endfunction

    function void bubble_down(int unsigned i);
      int unsigned l, r, top;
      logic signed [31:0] t;
      while (i < held) begin
        l = 2 * i + 1;
        r = 2 * i + 2;
        top = i;
        if (l < held && ranks_above(keys[l], keys[i])) top = l;
        if (r < held && ranks_above(keys[r], keys[top])) top = r;
        if (top == i) break;
        t = keys[i];
        keys[i] = keys[top];
        keys[top] = t;
        i = top;
      end
    endfunction

    function logic signed [31:0] pop_root();
      logic signed [31:0] v;
      v = keys[0];
      held--;
      keys[0] = keys[held];
      bubble_down(0);
      return v;
    endfunction

    function void push_result(logic signed [31:0] v, logic [2:0] st, int unsigned cnt, bit lst);
      hpq_pkg::hpq_out_t o;
      o.result_value = v;
      o.status = st;
      o.entry_count = cnt[5:0];
      o.last = lst;
      pending.push_back(o);
    endfunction

    function void note_command(hpq_pkg::hpq_in_t c);
      logic signed [31:0] v, moved;
      logic [2:0] st;
      logic signed [31:0] drained[hpq_pkg::Depth];
      int unsigned n;
      v = 0;
      st = hpq_pkg::StOk;
      case (c.action)
        hpq_pkg::ActInsert: begin
          if (held >= hpq_pkg::Depth) st = hpq_pkg::StFull;
          else begin
            held++;
            bubble_up(held - 1, c.key_value);
          end
        end
        hpq_pkg::ActExtract: begin
          if (held == 0) st = hpq_pkg::StEmpty;
          else v = pop_root();
        end
        hpq_pkg::ActPeek: begin
          if (held == 0) st = hpq_pkg::StEmpty;
          else v = keys[0];
        end
        hpq_pkg::ActRaise: begin
          if (c.slot_index >= held) st = hpq_pkg::StBadIdx;
          else if (!ranks_above(c.key_value, keys[c.slot_index])) st = hpq_pkg::StNotImpr;
          else bubble_up(c.slot_index, c.key_value);
        end
        hpq_pkg::ActRemove: begin
          if (held == 0) st = hpq_pkg::StEmpty;
          else if (c.slot_index >= held) st = hpq_pkg::StBadIdx;
          else begin
            v = keys[c.slot_index];
            held--;
            moved = keys[held];
            if (c.slot_index < held) begin
              keys[c.slot_index] = moved;
              if (c.slot_index > 0 && ranks_above(moved, keys[(c.slot_index - 1) / 2]))
                bubble_up(c.slot_index, moved);
              else
                bubble_down(c.slot_index);
            end
          end
        end
        hpq_pkg::ActDrain: begin
          if (held == 0) st = hpq_pkg::StEmpty;
          else begin
            n = held;
            for (int j = 0; j < n; j++) drained[j] = pop_root();
            for (int j = 0; j < n; j++)
              push_result(drained[n - 1 - j], hpq_pkg::StOk, 0, j + 1 == n);
            return;
          end
        end
        default: ;
      endcase
      push_result(v, st, held, 1'b1);
    endfunction

    function void check_result(hpq_pkg::hpq_out_t got);
      hpq_pkg::hpq_out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.result_value !== exp.result_value) begin
        $error("result_value: expected %0d, got %0d", exp.result_value, got.result_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  hpq_pkg::hpq_in_t cmd_i = '0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic result_valid_o;
  hpq_pkg::hpq_out_t result_o;

  heap_scoreboard sb = new();
  int send_idle_pct = 0;
  longint cycles = 0;

  binary_heap_priority_queue_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) sb.check_result(result_o);
    if (cycles > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Start stays high after an accepted item so that the next item can follow at once.
  task automatic send_command(hpq_pkg::hpq_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(c);
  endtask

  task automatic send(logic [2:0] act, logic signed [31:0] k, logic [4:0] s);
    hpq_pkg::hpq_in_t c;
    c.action = act;
    c.key_value = k;
    c.slot_index = s;
    send_command(c);
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_mode(bit m);
    drain_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_first = m;
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(20)) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic random_phase(int n);
    int unsigned r;
    logic [2:0] act;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) act = hpq_pkg::ActInsert;
      else if (r < 55) act = hpq_pkg::ActExtract;
      else if (r < 63) act = hpq_pkg::ActPeek;
      else if (r < 78) act = hpq_pkg::ActRaise;
      else if (r < 92) act = hpq_pkg::ActRemove;
      else if (r < 96) act = hpq_pkg::ActDrain;
      else act = 3'($urandom_range(7, 6));
      send(act, rand_key(), sb.held > 0 && $urandom_range(3) != 0 ?
           5'($urandom_range(sb.held - 1)) : 5'($urandom()));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(hpq_pkg::ActExtract, 0, 0);
    send(hpq_pkg::ActPeek, 0, 0);
    send(hpq_pkg::ActRemove, 0, 0);
    send(hpq_pkg::ActDrain, 0, 0);
    send(hpq_pkg::ActRaise, 5, 0);
    send(hpq_pkg::ActInsert, 32'sh7fffffff, 0);
    send(hpq_pkg::ActInsert, 32'sh80000000, 0);
    send(hpq_pkg::ActInsert, -1, 0);
    send(hpq_pkg::ActInsert, 7, 0);
    send(hpq_pkg::ActPeek, 0, 0);
    send(hpq_pkg::ActRaise, 32'sh80000000, 1);
    send(hpq_pkg::ActRaise, 100, 3);
    send(hpq_pkg::ActRaise, 5, 31);
    send(hpq_pkg::ActRemove, 0, 2);
    send(hpq_pkg::ActRemove, 0, 31);
    send(3'd6, 0, 0);
    send(3'd7, 32'shffffffff, 31);
    send(hpq_pkg::ActExtract, 0, 0);
    for (int i = 0; i < 33; i++) send(hpq_pkg::ActInsert, rand_key(), 5'($urandom()));
    send(hpq_pkg::ActRemove, 0, 31);
    send(hpq_pkg::ActDrain, 0, 0);
    set_mode(1'b0);
    send_idle_pct = 24;
    random_phase(150);
    set_mode(1'b1);
    send_idle_pct = 81;
    random_phase(100);
    drain_wait();
    send_idle_pct = 0;
    random_phase(100);
    set_mode(1'b0);
    random_phase(50);
    send(hpq_pkg::ActDrain, 0, 0);
    set_mode(1'b1);
    drain_wait();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> binary_heap_priority_queue_unit.f
sv/hpq_pkg.sv
sv/binary_heap_priority_queue_unit.sv
tb/binary_heap_priority_queue_unit_tb.sv
